[rtl/sct_pkg.sv]
// ----------------------------------------------------------------------------
// sct_pkg
// Types and constants shared by the socket connection table.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_CAP = 2'd2;

    localparam logic [31:0] LOCAL_ADDRESS_RESET = 32'hC0A8_0169;
    localparam logic [31:0] CLIENT_ADDRESS_RESET = 32'h0A00_0132;
    localparam logic [16:0] SEND_CAP_MAX = 17'd65536;

    localparam logic [15:0] EPHEMERAL_PORT_BASE = 16'd49152;
    localparam int EPHEMERAL_PORT_BITS = 14;
    localparam logic [15:0] CHILD_PORT_BASE = 16'd40000;
    localparam int CHILD_PORT_W = 14;
    localparam logic [CHILD_PORT_W-1:0] CHILD_PORT_SPAN = 14'd10000;

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_CLOSE = 3'd1;
    localparam logic [2:0] OP_CONNECT = 3'd2;
    localparam logic [2:0] OP_BIND = 3'd3;
    localparam logic [2:0] OP_LISTEN = 3'd4;
    localparam logic [2:0] OP_ACCEPT = 3'd5;
    localparam logic [2:0] OP_SEND = 3'd6;
    localparam logic [2:0] OP_RECV = 3'd7;

    localparam logic [2:0] SK_CREATED = 3'd0;
    localparam logic [2:0] SK_BOUND = 3'd1;
    localparam logic [2:0] SK_LISTENING = 3'd2;
    localparam logic [2:0] SK_CONNECTED = 3'd3;
    localparam logic [2:0] SK_CLOSED = 3'd4;

    localparam logic [2:0] RS_OK = 3'd0;
    localparam logic [2:0] RS_UNKNOWN = 3'd1;
    localparam logic [2:0] RS_STATE = 3'd2;
    localparam logic [2:0] RS_FULL = 3'd3;
    localparam logic [2:0] RS_BADARG = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] socket_id;
        logic [15:0] address_family;
        logic [15:0] socket_kind;
        logic [15:0] protocol_number;
        logic [31:0] endpoint_address;
        logic        endpoint_valid;
        logic [15:0] port_number;
        logic [31:0] byte_count;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] new_socket_id;
        logic [16:0] bytes_accepted;
        logic [2:0]  state_after;
    } rsp_t;

    typedef struct packed {
        logic [2:0]  state;
        logic [47:0] family_kind_proto;
        logic [47:0] local_endpoint;
        logic [47:0] remote_endpoint;
        logic [63:0] bytes_sent;
        logic [31:0] send_count;
        logic [31:0] recv_count;
    } entry_t;

endpackage

[rtl/socket_connection_table_unit.sv]
// ----------------------------------------------------------------------------
// socket_connection_table_unit
// Socket table with one read-modify-write of a table row per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req/req_valid/req_stall carries one socket operation per transaction;
//   rsp/rsp_valid/rsp_stall returns exactly one result per operation.
//   cfg_write/cfg_index/cfg_data write the local address, the client address
//   and the send cap; write them only while no operation is in flight.
// Flow:
//   The row is read from the table memory when the operation is accepted,
//   and modified and written back in S_EXEC, which waits while a stalled
//   result holds the output register. The new result is registered there
//   at write-back, and no new operation is taken before it (req_stall).
// Reset:
//   Ids restart at 1 and the table rows count as unwritten; no clearing
//   pass is needed, so operations are taken right after reset.
// Stall:
//   A stalled result holds in the output register; the next operation is
//   still accepted and waits with its row read until the result is taken.
// ----------------------------------------------------------------------------
module socket_connection_table_unit
    import sct_pkg::*;
#(
    parameter int MAX_SOCKETS = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp
);

    localparam int SLOT_W = (MAX_SOCKETS > 1) ? $clog2(MAX_SOCKETS) : 1;
    localparam int NID_W = $clog2(MAX_SOCKETS + 2);
    localparam int CMP_W = 17;
    localparam logic [NID_W-1:0] MAX_ID = NID_W'(MAX_SOCKETS);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } fsm_t;

    fsm_t                    state_reg;
    logic                    rsp_valid_reg;
    rsp_t                    rsp_reg;
    logic [NID_W-1:0]        next_id_reg;
    logic [CHILD_PORT_W-1:0] child_mod_reg;
    logic [31:0]             local_address_reg;
    logic [31:0]             client_address_reg;
    logic [16:0]             send_cap_reg;

    req_t                    item_reg;
    logic                    known_reg;
    logic [SLOT_W-1:0]       slot_reg;
    entry_t                  rd_row_reg;
    entry_t                  mem [MAX_SOCKETS];

    logic                    req_fire;
    logic                    exec_fire;
    logic                    known_in;
    logic [SLOT_W-1:0]       rd_addr;

    logic                    table_full;
    logic [SLOT_W-1:0]       new_slot;
    logic [2:0]              status_c;
    logic [15:0]             new_id_c;
    logic [16:0]             accepted_c;
    logic [2:0]              state_after_c;
    logic                    wr_en_c;
    logic [SLOT_W-1:0]       wr_addr_c;
    entry_t                  wr_row_c;
    logic                    id_used_c;
    logic [16:0]             cap_c;
    logic [64:0]             sum_c;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire = req_valid && !req_stall;
    assign exec_fire = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    assign known_in = (req.socket_id != 16'd0)
                      && ({1'b0, req.socket_id} < CMP_W'(next_id_reg));
    assign rd_addr = known_in ? SLOT_W'(req.socket_id - 16'd1) : '0;

    assign table_full = (next_id_reg > MAX_ID);
    assign new_slot = SLOT_W'(next_id_reg - NID_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= LOCAL_ADDRESS_RESET;
            client_address_reg <= CLIENT_ADDRESS_RESET;
            send_cap_reg <= SEND_CAP_MAX;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LOCAL_ADDRESS: local_address_reg <= cfg_data;
                CFG_CLIENT_ADDRESS: client_address_reg <= cfg_data;
                CFG_SEND_CAP: send_cap_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // hold the operation and read its row
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg <= req;
            known_reg <= known_in;
            slot_reg <= rd_addr;
            rd_row_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire && wr_en_c)
        begin
            mem[wr_addr_c] <= wr_row_c;
        end
    end

    always_comb
    begin
        status_c = RS_OK;
        new_id_c = '0;
        accepted_c = '0;
        state_after_c = SK_CREATED;
        wr_en_c = 1'b0;
        wr_addr_c = slot_reg;
        wr_row_c = rd_row_reg;
        id_used_c = 1'b0;
        cap_c = (send_cap_reg > SEND_CAP_MAX) ? SEND_CAP_MAX : send_cap_reg;
        sum_c = {1'b0, rd_row_reg.bytes_sent} + 65'(accepted_c);

        if (item_reg.operation == OP_CREATE)
        begin
            if (table_full)
            begin
                status_c = RS_FULL;
            end
            else
            begin
                wr_en_c = 1'b1;
                wr_addr_c = new_slot;
                wr_row_c = '0;
                wr_row_c.state = SK_CREATED;
                wr_row_c.family_kind_proto = {item_reg.address_family,
                                              item_reg.socket_kind,
                                              item_reg.protocol_number};
                new_id_c = 16'(next_id_reg);
                id_used_c = 1'b1;
            end
        end
        else if ((item_reg.operation == OP_CONNECT
                  && (item_reg.port_number == 16'd0 || !item_reg.endpoint_valid))
                 || (item_reg.operation == OP_BIND && !item_reg.endpoint_valid))
        begin
            status_c = RS_BADARG;
            state_after_c = known_reg ? rd_row_reg.state : SK_CREATED;
        end
        else if (!known_reg)
        begin
            status_c = RS_UNKNOWN;
        end
        else
        begin
            state_after_c = rd_row_reg.state;
            case (item_reg.operation)
                OP_CLOSE:
                begin
                    wr_en_c = 1'b1;
                    wr_row_c.state = SK_CLOSED;
                end
                OP_CONNECT:
                begin
                    if (rd_row_reg.state == SK_CLOSED)
                    begin
                        status_c = RS_STATE;
                    end
                    else
                    begin
                        wr_en_c = 1'b1;
                        wr_row_c.state = SK_CONNECTED;
                        wr_row_c.remote_endpoint = {item_reg.endpoint_address,
                                                    item_reg.port_number};
                        if (rd_row_reg.local_endpoint[15:0] == 16'd0)
                        begin
                            wr_row_c.local_endpoint = {local_address_reg,
                                EPHEMERAL_PORT_BASE
                                | 16'(item_reg.socket_id[EPHEMERAL_PORT_BITS-1:0])};
                        end
                    end
                end
                OP_BIND:
                begin
                    if (rd_row_reg.state != SK_CREATED)
                    begin
                        status_c = RS_STATE;
                    end
                    else
                    begin
                        wr_en_c = 1'b1;
                        wr_row_c.state = SK_BOUND;
                        wr_row_c.local_endpoint = {item_reg.endpoint_address,
                                                   item_reg.port_number};
                    end
                end
                OP_LISTEN:
                begin
                    if (rd_row_reg.state != SK_BOUND)
                    begin
                        status_c = RS_STATE;
                    end
                    else
                    begin
                        wr_en_c = 1'b1;
                        wr_row_c.state = SK_LISTENING;
                    end
                end
                OP_ACCEPT:
                begin
                    if (rd_row_reg.state != SK_LISTENING)
                    begin
                        status_c = RS_STATE;
                    end
                    else if (table_full)
                    begin
                        status_c = RS_FULL;
                    end
                    else
                    begin
                        wr_en_c = 1'b1;
                        wr_addr_c = new_slot;
                        wr_row_c = '0;
                        wr_row_c.state = SK_CONNECTED;
                        wr_row_c.family_kind_proto = rd_row_reg.family_kind_proto;
                        wr_row_c.local_endpoint = rd_row_reg.local_endpoint;
                        wr_row_c.remote_endpoint = {client_address_reg,
                            CHILD_PORT_BASE + 16'(child_mod_reg)};
                        new_id_c = 16'(next_id_reg);
                        id_used_c = 1'b1;
                    end
                end
                OP_SEND:
                begin
                    if (rd_row_reg.state != SK_CONNECTED)
                    begin
                        status_c = RS_STATE;
                    end
                    else
                    begin
                        accepted_c = (item_reg.byte_count < {15'd0, cap_c})
                                     ? item_reg.byte_count[16:0] : cap_c;
                        sum_c = {1'b0, rd_row_reg.bytes_sent} + 65'(accepted_c);
                        wr_en_c = 1'b1;
                        wr_row_c.bytes_sent = sum_c[64] ? '1 : sum_c[63:0];
                        if (rd_row_reg.send_count != '1)
                        begin
                            wr_row_c.send_count = rd_row_reg.send_count + 32'd1;
                        end
                    end
                end
                OP_RECV:
                begin
                    if (rd_row_reg.state != SK_CONNECTED)
                    begin
                        status_c = RS_STATE;
                    end
                    else
                    begin
                        wr_en_c = 1'b1;
                        if (rd_row_reg.recv_count != '1)
                        begin
                            wr_row_c.recv_count = rd_row_reg.recv_count + 32'd1;
                        end
                    end
                end
                default: ;
            endcase
            if (id_used_c)
            begin
                state_after_c = SK_CONNECTED;
            end
            else if (wr_en_c)
            begin
                state_after_c = wr_row_c.state;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg <= '0;
            next_id_reg <= NID_W'(1);
            child_mod_reg <= CHILD_PORT_W'(1);
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && !exec_fire)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (exec_fire)
                    begin
                        state_reg <= S_IDLE;
                        rsp_valid_reg <= 1'b1;
                        rsp_reg.status <= status_c;
                        rsp_reg.new_socket_id <= new_id_c;
                        rsp_reg.bytes_accepted <= accepted_c;
                        rsp_reg.state_after <= state_after_c;
                        if (id_used_c)
                        begin
                            next_id_reg <= next_id_reg + NID_W'(1);
                            child_mod_reg <= (child_mod_reg == CHILD_PORT_SPAN - 14'd1)
                                             ? '0 : child_mod_reg + 14'd1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_accept_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not enter execution");

    a_id_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (next_id_reg != '0) && (next_id_reg <= MAX_ID + NID_W'(1)))
        else $error("next id out of range");

    a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
        (next_id_reg == $past(next_id_reg))
        || (next_id_reg == $past(next_id_reg) + NID_W'(1)))
        else $error("next id moved by more than one");

    a_new_id_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.new_socket_id != 16'd0) |-> (rsp_reg.status == RS_OK))
        else $error("new id reported with failing status");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && rsp_valid_reg && rsp_stall) |=> (state_reg == S_EXEC))
        else $error("execution finished while output was stalled");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the socket connection table. It sends socket operations
// through the request channel and keeps its own copy of the table, which
// gives the expected result of every operation. Returned results are
// compared in order. Results are stalled and requests paused at random. The run covers a
// directed pass, several register settings, a full table and a final phase
// with no stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import sct_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;

    socket_connection_table_unit #(.MAX_SOCKETS(TABLE_DEPTH)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    logic [31:0] local_addr_reg;
    logic [31:0] client_addr_reg;
    logic [16:0] send_cap_reg;
    int unsigned next_sock_id;
    logic [2:0]  sock_state [TABLE_DEPTH];
    logic [47:0] sock_fkp [TABLE_DEPTH];
    logic [47:0] sock_local [TABLE_DEPTH];
    logic [47:0] sock_remote [TABLE_DEPTH];
    logic [63:0] sock_bytes [TABLE_DEPTH];
    logic [31:0] sock_sends [TABLE_DEPTH];
    logic [31:0] sock_recvs [TABLE_DEPTH];

    rsp_t        pending_results [$];
    rsp_t        last_result;
    int unsigned items_sent = 0;
    int unsigned error_count = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    bit          quiet = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int unsigned open_socket(logic [2:0] st);
        int unsigned slot;
        slot = next_sock_id - 1;
        sock_state[slot] = st;
        sock_fkp[slot] = '0;
        sock_local[slot] = '0;
        sock_remote[slot] = '0;
        sock_bytes[slot] = '0;
        sock_sends[slot] = '0;
        sock_recvs[slot] = '0;
        next_sock_id++;
        return slot;
    endfunction

    function automatic rsp_t predict_socket_op(req_t r);
        rsp_t        res;
        logic        known;
        int unsigned slot;
        int unsigned child;
        logic [2:0]  cur;
        logic [16:0] cap;
        logic [64:0] sum;
        res = '0;
        known = (r.socket_id != 0) && (r.socket_id < next_sock_id);
        slot = known ? r.socket_id - 1 : 0;
        cur = sock_state[slot];
        if (r.operation == OP_CREATE)
        begin
            if (next_sock_id - 1 >= TABLE_DEPTH)
                res.status = RS_FULL;
            else
            begin
                res.new_socket_id = 16'(next_sock_id);
                slot = open_socket(SK_CREATED);
                sock_fkp[slot] = {r.address_family, r.socket_kind, r.protocol_number};
                res.state_after = SK_CREATED;
            end
        end
        else if ((r.operation == OP_CONNECT && (r.port_number == 0 || !r.endpoint_valid))
                 || (r.operation == OP_BIND && !r.endpoint_valid))
        begin
            res.status = RS_BADARG;
            if (known)
                res.state_after = cur;
        end
        else if (!known)
            res.status = RS_UNKNOWN;
        else
        begin
            case (r.operation)
                OP_CLOSE:
                    sock_state[slot] = SK_CLOSED;
                OP_CONNECT:
                    if (cur == SK_CLOSED)
                        res.status = RS_STATE;
                    else
                    begin
                        sock_remote[slot] = {r.endpoint_address, r.port_number};
                        sock_state[slot] = SK_CONNECTED;
                        if (sock_local[slot][15:0] == 0)
                            sock_local[slot] = {local_addr_reg,
                                EPHEMERAL_PORT_BASE + {2'b00, r.socket_id[13:0]}};
                    end
                OP_BIND:
                    if (cur != SK_CREATED)
                        res.status = RS_STATE;
                    else
                    begin
                        sock_local[slot] = {r.endpoint_address, r.port_number};
                        sock_state[slot] = SK_BOUND;
                    end
                OP_LISTEN:
                    if (cur != SK_BOUND)
                        res.status = RS_STATE;
                    else
                        sock_state[slot] = SK_LISTENING;
                OP_ACCEPT:
                    if (cur != SK_LISTENING)
                        res.status = RS_STATE;
                    else if (next_sock_id - 1 >= TABLE_DEPTH)
                        res.status = RS_FULL;
                    else
                    begin
                        res.new_socket_id = 16'(next_sock_id);
                        child = open_socket(SK_CONNECTED);
                        sock_fkp[child] = sock_fkp[slot];
                        sock_local[child] = sock_local[slot];
                        sock_remote[child] = {client_addr_reg,
                            CHILD_PORT_BASE + 16'(res.new_socket_id % 16'd10000)};
                    end
                OP_SEND:
                    if (cur != SK_CONNECTED)
                        res.status = RS_STATE;
                    else
                    begin
                        cap = (send_cap_reg > SEND_CAP_MAX) ? SEND_CAP_MAX : send_cap_reg;
                        res.bytes_accepted = (r.byte_count < {15'd0, cap}) ?
                            r.byte_count[16:0] : cap;
                        sum = {1'b0, sock_bytes[slot]} + {48'd0, res.bytes_accepted};
                        sock_bytes[slot] = sum[64] ? '1 : sum[63:0];
                        if (sock_sends[slot] != '1)
                            sock_sends[slot]++;
                    end
                default:
                    if (cur != SK_CONNECTED)
                        res.status = RS_STATE;
                    else if (sock_recvs[slot] != '1)
                        sock_recvs[slot]++;
            endcase
            res.state_after = (res.new_socket_id != 0) ? SK_CONNECTED : sock_state[slot];
        end
        return res;
    endfunction

    function automatic req_t random_item(logic [2:0] op, logic [15:0] id, bit clean);
        req_t r;
        r.operation = op;
        r.socket_id = id;
        r.address_family = 16'($urandom);
        r.socket_kind = 16'($urandom);
        r.protocol_number = 16'($urandom);
        r.endpoint_address = $urandom;
        r.endpoint_valid = clean || ($urandom_range(0, 15) != 0);
        if (clean || $urandom_range(0, 15) != 0)
            r.port_number = 16'($urandom_range(1, 65535));
        else
            r.port_number = '0;
        case ($urandom_range(0, 3))
            0: r.byte_count = $urandom;
            1: r.byte_count = $urandom_range(0, 70000);
            2: r.byte_count = $urandom_range(0, 3);
            default: r.byte_count = $urandom_range(0, 2048);
        endcase
        return r;
    endfunction

    function automatic logic [15:0] known_id();
        if (next_sock_id <= 1)
            return 16'd0;
        return 16'($urandom_range(1, next_sock_id - 1));
    endfunction

    function automatic logic [2:0] send_or_recv();
        return ($urandom_range(0, 1) != 0) ? OP_SEND : OP_RECV;
    endfunction

    task automatic send_op(input req_t item);
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        last_result = predict_socket_op(item);
        pending_results.insert(pending_results.size(), last_result);
        items_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_LOCAL_ADDRESS: local_addr_reg = value;
            CFG_CLIENT_ADDRESS: client_addr_reg = value;
            CFG_SEND_CAP: send_cap_reg = value[16:0];
            default: ;
        endcase
    endtask

    task automatic run_traffic(input int unsigned count);
        int unsigned stop_at;
        logic [15:0] sock;
        logic [15:0] child;
        req_t        it;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    send_op(random_item(OP_CREATE, 16'($urandom), 1'b1));
                    sock = (last_result.new_socket_id != 0) ?
                        last_result.new_socket_id : known_id();
                    send_op(random_item(OP_CONNECT, sock, 1'b1));
                    repeat ($urandom_range(1, 4))
                        send_op(random_item(send_or_recv(), sock, 1'b1));
                end
                2:
                begin
                    send_op(random_item(OP_CREATE, 16'($urandom), 1'b1));
                    sock = (last_result.new_socket_id != 0) ?
                        last_result.new_socket_id : known_id();
                    send_op(random_item(OP_BIND, sock, 1'b1));
                    send_op(random_item(OP_LISTEN, sock, 1'b1));
                    repeat ($urandom_range(1, 2))
                    begin
                        send_op(random_item(OP_ACCEPT, sock, 1'b1));
                        child = last_result.new_socket_id;
                        if (child != 0)
                        begin
                            send_op(random_item(send_or_recv(), child, 1'b1));
                            if ($urandom_range(0, 2) == 0)
                                send_op(random_item(OP_CLOSE, child, 1'b1));
                        end
                    end
                end
                3, 4, 5, 6:
                    repeat ($urandom_range(1, 4))
                        send_op(random_item(3'($urandom_range(int'(OP_CLOSE), int'(OP_RECV))),
                                            known_id(), 1'b0));
                7:
                begin
                    case ($urandom_range(0, 2))
                        0: sock = 16'($urandom);
                        1: sock = 16'(next_sock_id);
                        default: sock = known_id();
                    endcase
                    it = random_item(3'($urandom), sock, 1'b0);
                    it.endpoint_valid = 1'($urandom);
                    send_op(it);
                end
                default:
                begin
                    sock = known_id();
                    send_op(random_item(OP_CLOSE, sock, 1'b1));
                    send_op(random_item(3'($urandom), sock, 1'b0));
                end
            endcase
        end
    endtask

    task automatic test_directed();
        req_t it;
        it = random_item(OP_CREATE, 16'hFFFF, 1'b1);
        it.address_family = '1;
        it.socket_kind = '1;
        it.protocol_number = '1;
        send_op(it);
        it = random_item(OP_CREATE, 16'h0000, 1'b1);
        it.address_family = '0;
        it.socket_kind = '0;
        it.protocol_number = '0;
        send_op(it);
        send_op(random_item(OP_CLOSE, 16'd0, 1'b1));
        send_op(random_item(OP_SEND, 16'hFFFF, 1'b1));
        send_op(random_item(OP_RECV, 16'd3, 1'b1));
        it = random_item(OP_CONNECT, 16'd1, 1'b1);
        it.port_number = '0;
        send_op(it);
        it = random_item(OP_CONNECT, 16'd1, 1'b1);
        it.endpoint_valid = 1'b0;
        it.port_number = '1;
        send_op(it);
        it = random_item(OP_CONNECT, 16'd0, 1'b1);
        it.port_number = '0;
        send_op(it);
        it = random_item(OP_BIND, 16'd2, 1'b1);
        it.endpoint_valid = 1'b0;
        send_op(it);
        it = random_item(OP_BIND, 16'd1, 1'b1);
        it.endpoint_address = '1;
        it.port_number = '0;
        send_op(it);
        send_op(random_item(OP_LISTEN, 16'd2, 1'b1));
        send_op(random_item(OP_LISTEN, 16'd1, 1'b1));
        send_op(random_item(OP_ACCEPT, 16'd1, 1'b1));
        send_op(random_item(OP_ACCEPT, 16'd2, 1'b1));
        send_op(random_item(OP_RECV, 16'd1, 1'b1));
        it = random_item(OP_CONNECT, 16'd2, 1'b1);
        it.endpoint_address = '0;
        it.port_number = '1;
        send_op(it);
        send_op(random_item(OP_CONNECT, 16'd2, 1'b1));
        it = random_item(OP_SEND, 16'd2, 1'b1);
        it.byte_count = '1;
        send_op(it);
        it.byte_count = '0;
        send_op(it);
        send_op(random_item(OP_CLOSE, 16'd3, 1'b1));
        send_op(random_item(OP_CLOSE, 16'd3, 1'b1));
        send_op(random_item(OP_CONNECT, 16'd3, 1'b1));
        send_op(random_item(OP_SEND, 16'd3, 1'b1));
        send_op(random_item(OP_CONNECT, 16'd1, 1'b1));
        send_op(random_item(OP_BIND, 16'd1, 1'b1));
    endtask

    task automatic test_config_phase(input logic [31:0] local_addr,
                                     input logic [31:0] client_addr,
                                     input logic [31:0] cap,
                                     input int unsigned count);
        drain();
        write_reg(CFG_LOCAL_ADDRESS, local_addr);
        write_reg(CFG_CLIENT_ADDRESS, client_addr);
        write_reg(CFG_SEND_CAP, cap);
        cfg_write <= 1'b0;
        run_traffic(count);
    endtask

    task automatic test_table_full();
        logic [15:0] listener;
        int unsigned slot;
        listener = '0;
        for (slot = 0; slot + 1 < next_sock_id; slot++)
            if (sock_state[slot] == SK_LISTENING)
                listener = 16'(slot + 1);
        while (next_sock_id <= TABLE_DEPTH)
            send_op(random_item(OP_CREATE, 16'($urandom), 1'b1));
        send_op(random_item(OP_CREATE, 16'($urandom), 1'b1));
        if (listener != 0)
            send_op(random_item(OP_ACCEPT, listener, 1'b1));
    endtask

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected transaction: status %0d id %0d bytes %0d state %0d",
                             rsp.status, rsp.new_socket_id, rsp.bytes_accepted,
                             rsp.state_after);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status || rsp.new_socket_id !== want.new_socket_id
                    || rsp.bytes_accepted !== want.bytes_accepted
                    || rsp.state_after !== want.state_after)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"mismatch: status exp %0d got %0d, id exp %0d got %0d,",
                                  " bytes exp %0d got %0d, state exp %0d got %0d"},
                                 want.status, rsp.status, want.new_socket_id,
                                 rsp.new_socket_id, want.bytes_accepted, rsp.bytes_accepted,
                                 want.state_after, rsp.state_after);
                end
            end
        end
        if (stall_left != 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        local_addr_reg = LOCAL_ADDRESS_RESET;
        client_addr_reg = CLIENT_ADDRESS_RESET;
        send_cap_reg = SEND_CAP_MAX;
        next_sock_id = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_phase(32'h0, 32'h0, 32'h0, 375);
        test_config_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_FFFF, 375);
        test_config_phase($urandom, $urandom, 32'd1, 375);
        test_config_phase($urandom, $urandom, $urandom_range(0, 65536), 375);
        test_table_full();
        drain();
        quiet = 1'b1;
        test_config_phase(LOCAL_ADDRESS_RESET, CLIENT_ADDRESS_RESET, 32'(SEND_CAP_MAX), 375);
        drain();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[files.f]
rtl/sct_pkg.sv
rtl/socket_connection_table_unit.sv
verif/tb_top.sv
